// ----- hw/rtl/mfrag_pkg.sv -----
// mfrag_pkg: widths, register indexes, control word and status types and the
// microcode program of the message fragmenter.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package mfrag_pkg;

    localparam int LENGTH_BITS = 24;
    localparam int BODY_LEN_W  = 24;
    localparam int LEN_W       = (LENGTH_BITS < BODY_LEN_W) ? LENGTH_BITS : BODY_LEN_W;
    localparam int BYTE_W      = 8;
    localparam int SIZE_W      = 16;
    localparam int NUM_W       = LEN_W + 1;
    localparam int DIV_CNT_W   = $clog2(NUM_W + 1);
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int STEP_W      = 5;

    localparam logic [CFG_IDX_W-1:0] REG_SINGLE_KIND = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_CHUNK_KIND  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_MAX_BODY    = CFG_IDX_W'(2);

    localparam logic [BYTE_W-1:0] SINGLE_KIND_RST = BYTE_W'(0);
    localparam logic [BYTE_W-1:0] CHUNK_KIND_RST  = BYTE_W'(1);
    localparam logic [SIZE_W-1:0] MAX_BODY_RST    = SIZE_W'(1024);

    typedef enum logic [3:0] {
        C_NONE,
        C_ALWAYS,
        C_NO_INPUT,
        C_ZERO_LEN,
        C_NOT_FIRST,
        C_FITS,
        C_DIV_BUSY,
        C_SINGLE,
        C_FRAGS_DONE,
        C_MID_FRAG
    } cond_t;

    typedef enum logic [2:0] {
        SRC_SINGLE_KIND,
        SRC_CHUNK_KIND,
        SRC_TYPE,
        SRC_IDX_LO,
        SRC_IDX_HI,
        SRC_TOT_LO,
        SRC_TOT_HI,
        SRC_DATA
    } src_t;

    typedef enum logic [1:0] {
        END_ZERO,
        END_ONE,
        END_FRAG,
        END_MSG
    } endsel_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LATCH,
        OP_DIV_START,
        OP_LOAD_TOTAL,
        OP_SINGLE,
        OP_FRAG_ADV,
        OP_MSG_ADV,
        OP_CLEAR
    } op_t;

    typedef struct packed {
        logic              emit;
        src_t              src;
        endsel_t           end_sel;
        logic              last;
        cond_t             cond;
        logic [STEP_W-1:0] target;
        op_t               op;
    } ctrl_t;

    typedef struct packed {
        logic first;
        logic zero_len;
        logic fits;
        logic div_busy;
        logic single;
        logic frags_done;
        logic mid_frag;
        logic out_free;
    } stat_t;

    // program addresses
    localparam logic [STEP_W-1:0] A_IDLE    = STEP_W'(0);
    localparam logic [STEP_W-1:0] A_ZCHK    = STEP_W'(1);
    localparam logic [STEP_W-1:0] A_FCHK    = STEP_W'(2);
    localparam logic [STEP_W-1:0] A_FITCHK  = STEP_W'(3);
    localparam logic [STEP_W-1:0] A_DIVGO   = STEP_W'(4);
    localparam logic [STEP_W-1:0] A_DIVWAIT = STEP_W'(5);
    localparam logic [STEP_W-1:0] A_TOTAL   = STEP_W'(6);
    localparam logic [STEP_W-1:0] A_MODE    = STEP_W'(7);
    localparam logic [STEP_W-1:0] A_FRAGCHK = STEP_W'(8);
    localparam logic [STEP_W-1:0] A_HDRCHK  = STEP_W'(9);
    localparam logic [STEP_W-1:0] A_CH0     = STEP_W'(10);
    localparam logic [STEP_W-1:0] A_CH1     = STEP_W'(11);
    localparam logic [STEP_W-1:0] A_CH2     = STEP_W'(12);
    localparam logic [STEP_W-1:0] A_CH3     = STEP_W'(13);
    localparam logic [STEP_W-1:0] A_CH4     = STEP_W'(14);
    localparam logic [STEP_W-1:0] A_CH5     = STEP_W'(15);
    localparam logic [STEP_W-1:0] A_CBODY   = STEP_W'(16);
    localparam logic [STEP_W-1:0] A_SHDR0   = STEP_W'(17);
    localparam logic [STEP_W-1:0] A_SHDR1   = STEP_W'(18);
    localparam logic [STEP_W-1:0] A_SBODY   = STEP_W'(19);
    localparam logic [STEP_W-1:0] A_ZHDR0   = STEP_W'(20);
    localparam logic [STEP_W-1:0] A_ZHDR1   = STEP_W'(21);
    localparam logic [STEP_W-1:0] A_FINISH  = STEP_W'(22);

    function automatic ctrl_t cw_make(
        input logic              emit,
        input src_t              src,
        input endsel_t           end_sel,
        input logic              last,
        input cond_t             cond,
        input logic [STEP_W-1:0] target,
        input op_t               op
    );
        ctrl_t w;
        w.emit    = emit;
        w.src     = src;
        w.end_sel = end_sel;
        w.last    = last;
        w.cond    = cond;
        w.target  = target;
        w.op      = op;
        return w;
    endfunction

    // one control word per step; a true condition jumps to target, else falls through
    function automatic ctrl_t ucode_rom(input logic [STEP_W-1:0] step);
        ctrl_t w;
        unique case (step)
            A_IDLE:    w = cw_make(1'b0, SRC_DATA, END_ZERO, 1'b0, C_NO_INPUT, A_IDLE, OP_LATCH);
            A_ZCHK:    w = cw_make(1'b0, SRC_DATA, END_ZERO, 1'b0, C_ZERO_LEN, A_ZHDR0, OP_NONE);
            A_FCHK:    w = cw_make(1'b0, SRC_DATA, END_ZERO, 1'b0, C_NOT_FIRST, A_MODE, OP_NONE);
            A_FITCHK:  w = cw_make(1'b0, SRC_DATA, END_ZERO, 1'b0, C_FITS, A_SHDR0, OP_NONE);
            A_DIVGO:   w = cw_make(1'b0, SRC_DATA, END_ZERO, 1'b0, C_NONE, A_IDLE,
                                   OP_DIV_START);
            A_DIVWAIT: w = cw_make(1'b0, SRC_DATA, END_ZERO, 1'b0, C_DIV_BUSY, A_DIVWAIT,
                                   OP_NONE);
            A_TOTAL:   w = cw_make(1'b0, SRC_DATA, END_ZERO, 1'b0, C_NONE, A_IDLE,
                                   OP_LOAD_TOTAL);
            A_MODE:    w = cw_make(1'b0, SRC_DATA, END_ZERO, 1'b0, C_SINGLE, A_SBODY, OP_NONE);
            A_FRAGCHK: w = cw_make(1'b0, SRC_DATA, END_ZERO, 1'b0, C_FRAGS_DONE, A_FINISH,
                                   OP_NONE);
            A_HDRCHK:  w = cw_make(1'b0, SRC_DATA, END_ZERO, 1'b0, C_MID_FRAG, A_CBODY,
                                   OP_NONE);
            A_CH0:     w = cw_make(1'b1, SRC_CHUNK_KIND, END_ZERO, 1'b0, C_NONE, A_IDLE,
                                   OP_NONE);
            A_CH1:     w = cw_make(1'b1, SRC_TYPE, END_ZERO, 1'b0, C_NONE, A_IDLE, OP_NONE);
            A_CH2:     w = cw_make(1'b1, SRC_IDX_LO, END_ZERO, 1'b0, C_NONE, A_IDLE, OP_NONE);
            A_CH3:     w = cw_make(1'b1, SRC_IDX_HI, END_ZERO, 1'b0, C_NONE, A_IDLE, OP_NONE);
            A_CH4:     w = cw_make(1'b1, SRC_TOT_LO, END_ZERO, 1'b0, C_NONE, A_IDLE, OP_NONE);
            A_CH5:     w = cw_make(1'b1, SRC_TOT_HI, END_ZERO, 1'b0, C_NONE, A_IDLE, OP_NONE);
            A_CBODY:   w = cw_make(1'b1, SRC_DATA, END_FRAG, 1'b1, C_ALWAYS, A_FINISH,
                                   OP_FRAG_ADV);
            A_SHDR0:   w = cw_make(1'b1, SRC_SINGLE_KIND, END_ZERO, 1'b0, C_NONE, A_IDLE,
                                   OP_SINGLE);
            A_SHDR1:   w = cw_make(1'b1, SRC_TYPE, END_ZERO, 1'b0, C_NONE, A_IDLE, OP_NONE);
            A_SBODY:   w = cw_make(1'b1, SRC_DATA, END_MSG, 1'b1, C_ALWAYS, A_FINISH,
                                   OP_NONE);
            A_ZHDR0:   w = cw_make(1'b1, SRC_SINGLE_KIND, END_ZERO, 1'b0, C_NONE, A_IDLE,
                                   OP_NONE);
            A_ZHDR1:   w = cw_make(1'b1, SRC_TYPE, END_ONE, 1'b1, C_ALWAYS, A_IDLE, OP_CLEAR);
            A_FINISH:  w = cw_make(1'b0, SRC_DATA, END_ZERO, 1'b0, C_ALWAYS, A_IDLE,
                                   OP_MSG_ADV);
            default:   w = cw_make(1'b0, SRC_DATA, END_ZERO, 1'b0, C_ALWAYS, A_IDLE, OP_NONE);
        endcase
        return w;
    endfunction

endpackage

// ----- hw/rtl/mfrag_if.sv -----
// mfrag_in_if and mfrag_out_if: valid/ready channels for body bytes in and
// wire bytes out. Depends on mfrag_pkg for field widths.
`timescale 1ns / 1ps

interface mfrag_in_if import mfrag_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [BYTE_W-1:0]     data_byte;
    logic [BYTE_W-1:0]     msg_type;
    logic [BODY_LEN_W-1:0] body_length;

    modport source (output valid, data_byte, msg_type, body_length, input ready);
    modport sink   (input valid, data_byte, msg_type, body_length, output ready);
endinterface

interface mfrag_out_if import mfrag_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              datagram_end;
    logic              run_last;

    modport source (output valid, out_byte, datagram_end, run_last, input ready);
    modport sink   (input valid, out_byte, datagram_end, run_last, output ready);
endinterface

// ----- hw/rtl/mfrag_div.sv -----
// mfrag_div: restoring divider, one quotient bit per cycle, for the fragment
// count. Depends on mfrag_pkg.
`timescale 1ns / 1ps

module mfrag_div import mfrag_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [NUM_W-1:0]  num,
    input  logic [SIZE_W-1:0] den,
    output logic              busy,
    output logic [SIZE_W-1:0] quot
);

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [SIZE_W-1:0]    rem_reg, rem_next;
    logic [NUM_W-1:0]     q_reg, q_next;
    logic [SIZE_W:0]      trial;
    logic [SIZE_W:0]      diff;
    logic                 take;

    assign trial = {rem_reg, q_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den};
    assign take  = ~diff[SIZE_W];

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(NUM_W);
            rem_next  = '0;
            q_next    = num;
        end
        else if (busy_reg)
        begin
            rem_next  = take ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
            q_next    = {q_reg[NUM_W-2:0], take};
            cnt_next  = cnt_reg - DIV_CNT_W'(1);
            busy_next = (cnt_reg != DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign busy = busy_reg;
    assign quot = q_reg[SIZE_W-1:0];

endmodule

// ----- hw/rtl/mfrag_seq.sv -----
// mfrag_seq: step counter and microcode read-out with conditional jumps.
// Depends on mfrag_pkg for the control word, status and program.
`timescale 1ns / 1ps

module mfrag_seq import mfrag_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  stat_t stat,
    output ctrl_t cw,
    output logic  advance,
    output logic  in_ready
);

    logic [STEP_W-1:0] step_reg, step_next;
    logic              cond_true;

    assign cw       = ucode_rom(step_reg);
    assign in_ready = (cw.op == OP_LATCH);
    // an emitting step holds until the output register is free
    assign advance  = ~cw.emit | stat.out_free;

    always_comb
    begin
        unique case (cw.cond)
            C_NONE:       cond_true = 1'b0;
            C_ALWAYS:     cond_true = 1'b1;
            C_NO_INPUT:   cond_true = ~in_valid;
            C_ZERO_LEN:   cond_true = stat.first & stat.zero_len;
            C_NOT_FIRST:  cond_true = ~stat.first;
            C_FITS:       cond_true = stat.fits;
            C_DIV_BUSY:   cond_true = stat.div_busy;
            C_SINGLE:     cond_true = stat.single;
            C_FRAGS_DONE: cond_true = stat.frags_done;
            C_MID_FRAG:   cond_true = stat.mid_frag;
            default:      cond_true = 1'b0;
        endcase
    end

    always_comb
    begin
        if (!advance)
            step_next = step_reg;
        else if (cond_true)
            step_next = cw.target;
        else
            step_next = step_reg + STEP_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= A_IDLE;
        else
            step_reg <= step_next;
    end

endmodule

// ----- hw/rtl/mfrag_dp.sv -----
// mfrag_dp: message and fragment state, latched input word, byte select and
// output register, driven by the control word. Depends on mfrag_pkg, mfrag_div.
`timescale 1ns / 1ps

module mfrag_dp import mfrag_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ctrl_t                 cw,
    input  logic                  advance,
    input  logic                  in_fire,
    input  logic [BYTE_W-1:0]     in_data,
    input  logic [BYTE_W-1:0]     in_type,
    input  logic [BODY_LEN_W-1:0] in_len,
    input  logic [BYTE_W-1:0]     single_kind,
    input  logic [BYTE_W-1:0]     chunk_kind,
    input  logic [SIZE_W-1:0]     size,
    input  logic                  out_ready,
    output stat_t                 stat,
    output logic                  out_valid,
    output logic [BYTE_W-1:0]     out_byte,
    output logic                  out_end,
    output logic                  out_last
);

    logic [BYTE_W-1:0] data_reg, data_next;
    logic [BYTE_W-1:0] type_reg, type_next;
    logic [LEN_W-1:0]  len_reg, len_next;

    logic [LEN_W-1:0]  pos_reg, pos_next;
    logic [SIZE_W-1:0] off_reg, off_next;
    logic [SIZE_W-1:0] idx_reg, idx_next;
    logic [SIZE_W-1:0] total_reg, total_next;
    logic              chunked_reg, chunked_next;

    logic              ov_reg, ov_next;
    logic [BYTE_W-1:0] ob_reg, ob_next;
    logic              oe_reg, oe_next;
    logic              ol_reg, ol_next;

    logic [LEN_W:0]    pos_inc;
    logic [SIZE_W:0]   off_inc;
    logic              msg_end;
    logic              frag_end;
    logic [NUM_W-1:0]  div_num;
    logic              div_busy;
    logic [SIZE_W-1:0] div_quot;
    logic              load_out;
    logic [BYTE_W-1:0] sel_byte;
    logic              sel_end;

    assign pos_inc  = {1'b0, pos_reg} + (LEN_W+1)'(1);
    assign off_inc  = {1'b0, off_reg} + (SIZE_W+1)'(1);
    assign msg_end  = (pos_inc >= {1'b0, len_reg});
    assign frag_end = (off_inc >= {1'b0, size}) | msg_end;

    // ceil(len / size) as (len + size - 1) / size
    assign div_num = NUM_W'(len_reg) + NUM_W'(size) - NUM_W'(1);

    mfrag_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cw.op == OP_DIV_START),
        .num   (div_num),
        .den   (size),
        .busy  (div_busy),
        .quot  (div_quot)
    );

    assign stat.first      = (pos_reg == '0);
    assign stat.zero_len   = (len_reg == '0);
    assign stat.fits       = (len_reg <= LEN_W'(size));
    assign stat.div_busy   = div_busy;
    assign stat.single     = ~chunked_reg;
    assign stat.frags_done = (idx_reg >= total_reg);
    assign stat.mid_frag   = (off_reg != '0);
    assign stat.out_free   = ~ov_reg | out_ready;

    always_comb
    begin
        data_next    = data_reg;
        type_next    = type_reg;
        len_next     = len_reg;
        pos_next     = pos_reg;
        off_next     = off_reg;
        idx_next     = idx_reg;
        total_next   = total_reg;
        chunked_next = chunked_reg;
        unique case (cw.op)
            OP_LATCH:
            begin
                if (in_fire)
                begin
                    data_next = in_data;
                    type_next = in_type;
                    len_next  = in_len[LEN_W-1:0];
                end
            end
            OP_DIV_START:
            begin
                chunked_next = 1'b1;
                idx_next     = '0;
                off_next     = '0;
            end
            OP_LOAD_TOTAL:
                total_next = div_quot;
            OP_SINGLE:
            begin
                if (advance)
                    chunked_next = 1'b0;
            end
            OP_FRAG_ADV:
            begin
                if (advance)
                begin
                    if (frag_end)
                    begin
                        idx_next = idx_reg + SIZE_W'(1);
                        off_next = '0;
                    end
                    else
                        off_next = off_inc[SIZE_W-1:0];
                end
            end
            OP_MSG_ADV:
            begin
                if (msg_end)
                begin
                    pos_next     = '0;
                    off_next     = '0;
                    idx_next     = '0;
                    total_next   = '0;
                    chunked_next = 1'b0;
                end
                else
                    pos_next = pos_inc[LEN_W-1:0];
            end
            OP_CLEAR:
            begin
                if (advance)
                begin
                    pos_next     = '0;
                    off_next     = '0;
                    idx_next     = '0;
                    total_next   = '0;
                    chunked_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        case (cw.src)
            SRC_SINGLE_KIND: sel_byte = single_kind;
            SRC_CHUNK_KIND:  sel_byte = chunk_kind;
            SRC_TYPE:        sel_byte = type_reg;
            SRC_IDX_LO:      sel_byte = idx_reg[BYTE_W-1:0];
            SRC_IDX_HI:      sel_byte = idx_reg[SIZE_W-1:BYTE_W];
            SRC_TOT_LO:      sel_byte = total_reg[BYTE_W-1:0];
            SRC_TOT_HI:      sel_byte = total_reg[SIZE_W-1:BYTE_W];
            default:         sel_byte = data_reg;
        endcase
        case (cw.end_sel)
            END_ONE:  sel_end = 1'b1;
            END_FRAG: sel_end = frag_end;
            END_MSG:  sel_end = msg_end;
            default:  sel_end = 1'b0;
        endcase
    end

    assign load_out = cw.emit & advance;

    always_comb
    begin
        ob_next = ob_reg;
        oe_next = oe_reg;
        ol_next = ol_reg;
        if (load_out)
        begin
            ov_next = 1'b1;
            ob_next = sel_byte;
            oe_next = sel_end;
            ol_next = cw.last;
        end
        else if (out_ready)
            ov_next = 1'b0;
        else
            ov_next = ov_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            off_reg     <= '0;
            idx_reg     <= '0;
            total_reg   <= '0;
            chunked_reg <= 1'b0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            off_reg     <= off_next;
            idx_reg     <= idx_next;
            total_reg   <= total_next;
            chunked_reg <= chunked_next;
            ov_reg      <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        type_reg <= type_next;
        len_reg  <= len_next;
        ob_reg   <= ob_next;
        oe_reg   <= oe_next;
        ol_reg   <= ol_next;
    end

    assign out_valid = ov_reg;
    assign out_byte  = ob_reg;
    assign out_end   = oe_reg;
    assign out_last  = ol_reg;

endmodule

// ----- hw/rtl/message_fragmenter_with_headers.sv -----
// message_fragmenter_with_headers: top level; configuration registers, the
// microcode sequencer and the datapath. Depends on mfrag_pkg, mfrag_if,
// mfrag_seq, mfrag_dp.
//
//  channel  dir  handshake       payload
//  rx       in   valid/ready     data_byte, msg_type, body_length
//  tx       out  valid/ready     out_byte, datagram_end, run_last
//  cfg      in   cfg_we          cfg_index, cfg_wdata
//
// each emitted byte is one microcode step; a fragment start adds 6 header steps,
// and the first byte of a fragmented message first runs the divider over NUM_W
// quotient bits for the fragment count
// the sequencer holds on any emit step while the output register is full and not taken
// reset puts the sequencer at its idle step and clears the message position, fragment and output-valid state
`timescale 1ns / 1ps

module message_fragmenter_with_headers import mfrag_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    mfrag_in_if.sink             rx,
    mfrag_out_if.source          tx
);

    logic [BYTE_W-1:0] single_kind_reg, single_kind_next;
    logic [BYTE_W-1:0] chunk_kind_reg, chunk_kind_next;
    logic [SIZE_W-1:0] max_body_reg, max_body_next;
    logic [SIZE_W-1:0] size_eff;

    ctrl_t cw;
    stat_t stat;
    logic  advance;
    logic  in_ready;

    always_comb
    begin
        single_kind_next = single_kind_reg;
        chunk_kind_next  = chunk_kind_reg;
        max_body_next    = max_body_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SINGLE_KIND: single_kind_next = cfg_wdata[BYTE_W-1:0];
                REG_CHUNK_KIND:  chunk_kind_next  = cfg_wdata[BYTE_W-1:0];
                REG_MAX_BODY:    max_body_next    = cfg_wdata[SIZE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            single_kind_reg <= SINGLE_KIND_RST;
            chunk_kind_reg  <= CHUNK_KIND_RST;
            max_body_reg    <= MAX_BODY_RST;
        end
        else
        begin
            single_kind_reg <= single_kind_next;
            chunk_kind_reg  <= chunk_kind_next;
            max_body_reg    <= max_body_next;
        end
    end

    // a size of zero counts as one
    assign size_eff = (max_body_reg == '0) ? SIZE_W'(1) : max_body_reg;

    mfrag_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rx.valid),
        .stat     (stat),
        .cw       (cw),
        .advance  (advance),
        .in_ready (in_ready)
    );

    mfrag_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cw          (cw),
        .advance     (advance),
        .in_fire     (rx.valid & in_ready),
        .in_data     (rx.data_byte),
        .in_type     (rx.msg_type),
        .in_len      (rx.body_length),
        .single_kind (single_kind_reg),
        .chunk_kind  (chunk_kind_reg),
        .size        (size_eff),
        .out_ready   (tx.ready),
        .stat        (stat),
        .out_valid   (tx.valid),
        .out_byte    (tx.out_byte),
        .out_end     (tx.datagram_end),
        .out_last    (tx.run_last)
    );

    assign rx.ready = in_ready;

endmodule

// ----- hw/rtl/mfrag_checker.sv -----
// mfrag_checker: port-level assertions on the fragmenter, bound to the top
// level. Depends on mfrag_pkg and message_fragmenter_with_headers.
`timescale 1ns / 1ps

module mfrag_checker import mfrag_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              rx_valid,
    input logic              rx_ready,
    input logic              tx_valid,
    input logic              tx_ready,
    input logic [BYTE_W-1:0] tx_out_byte,
    input logic              tx_datagram_end,
    input logic              tx_run_last
);

    // a stalled word holds
    a_tx_hold: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid && !tx_ready |=> tx_valid && $stable(tx_out_byte)
            && $stable(tx_datagram_end) && $stable(tx_run_last))
        else $error("output word changed while stalled");

    // one byte at a time: no word taken right after another
    a_rx_gap: assert property (@(posedge clk) disable iff (!rst_n)
        rx_valid && rx_ready |=> !rx_ready)
        else $error("input taken on back-to-back cycles");

    // every datagram closes on the last word of a run
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid && tx_datagram_end |-> tx_run_last)
        else $error("datagram end not on last word of run");

    // a run still in flight keeps the input closed
    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid && !tx_run_last |-> !rx_ready)
        else $error("input open while run incomplete");

endmodule

bind message_fragmenter_with_headers mfrag_checker u_mfrag_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .rx_valid        (rx.valid),
    .rx_ready        (rx.ready),
    .tx_valid        (tx.valid),
    .tx_ready        (tx.ready),
    .tx_out_byte     (tx.out_byte),
    .tx_datagram_end (tx.datagram_end),
    .tx_run_last     (tx.run_last)
);
